// File: src/fps_pkg.sv
// shared types, command codes and microcode table of the fenwick prefix-sum tree
package fps_pkg;

    localparam int DATA_W = 32;
    localparam int SIZE_W = 11;
    // walk position: one bit above the index so the upward walk can step past the size
    localparam int POS_W  = SIZE_W + 1;
    localparam int STEP_W = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // datapath action of one step
    typedef enum logic [2:0] {
        A_NOP    = 3'd0,
        A_FETCH  = 3'd1,
        A_READ   = 3'd2,
        A_WRITE  = 3'd3,
        A_CLAMP  = 3'd4,
        A_ACC    = 3'd5,
        A_CLEAR  = 3'd6,
        A_RESULT = 3'd7
    } act_t;

    // how the step counter moves on
    typedef enum logic [2:0] {
        C_SEQ      = 3'd0,
        C_GO       = 3'd1,
        C_DISPATCH = 3'd2,
        C_OUT      = 3'd3,
        C_IN       = 3'd4,
        C_SWEEP    = 3'd5,
        C_WAIT_OUT = 3'd6
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    localparam logic [STEP_W-1:0] STEP_INIT     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADD_CHK  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ADD_RD   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADD_WR   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADD_END  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_QRY_CLMP = 4'd6;
    localparam logic [STEP_W-1:0] STEP_QRY_RD   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_QRY_ACC  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_QRY_END  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_CLR      = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FIN      = 4'd11;

    function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        case (step)
            STEP_INIT:     w = '{A_CLEAR,  C_SWEEP,    STEP_INIT};
            STEP_FETCH:    w = '{A_FETCH,  C_DISPATCH, STEP_FETCH};
            STEP_ADD_CHK:  w = '{A_NOP,    C_OUT,      STEP_FIN};
            STEP_ADD_RD:   w = '{A_READ,   C_SEQ,      STEP_ADD_RD};
            STEP_ADD_WR:   w = '{A_WRITE,  C_IN,       STEP_ADD_RD};
            STEP_ADD_END:  w = '{A_NOP,    C_GO,       STEP_FIN};
            STEP_QRY_CLMP: w = '{A_CLAMP,  C_OUT,      STEP_FIN};
            STEP_QRY_RD:   w = '{A_READ,   C_SEQ,      STEP_QRY_RD};
            STEP_QRY_ACC:  w = '{A_ACC,    C_IN,       STEP_QRY_RD};
            STEP_QRY_END:  w = '{A_NOP,    C_GO,       STEP_FIN};
            STEP_CLR:      w = '{A_CLEAR,  C_SWEEP,    STEP_CLR};
            STEP_FIN:      w = '{A_RESULT, C_WAIT_OUT, STEP_FETCH};
            default:       w = '{A_NOP,    C_GO,       STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// File: src/fps_if.sv
// channel interfaces: command words in, result words out, size register writes
interface fps_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [10:0]        index;
    logic signed [31:0] delta;

    modport source (output valid, output command, output index, output delta, input ready);
    modport sink   (input valid, input command, input index, input delta, output ready);
endinterface

interface fps_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] prefix_sum;

    modport source (output valid, output prefix_sum, input ready);
    modport sink   (input valid, input prefix_sum, output ready);
endinterface

interface fps_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] active_size;

    modport source (output valid, output active_size, input ready);
    modport sink   (input valid, input active_size, output ready);
endinterface

// File: src/fenwick_prefix_sum_tree.sv
// an add or query word walks its tree nodes, one after another, from the accepted word to its result;
// a clear word sweeps the store one entry a cycle over min(MAX_POSITIONS, 2047) entries
// one word in flight at a time; the next word is taken while the result waits to be read;
// the single memory port sets the pace: one read then one write or add per node
// reset: size register to 1024, then a clearing pass over min(MAX_POSITIONS, 2047) entries
module fenwick_prefix_sum_tree #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    fps_cmd_if.sink   items,
    fps_res_if.source results,
    fps_cfg_if.sink   size_cfg
);
    import fps_pkg::*;

    localparam int AW    = $clog2(MAX_POSITIONS);
    localparam int XW    = (AW > POS_W) ? AW : POS_W;
    // only positions up to the largest index can ever hold data
    localparam int CLR_N = (MAX_POSITIONS < 2047) ? MAX_POSITIONS : 2047;
    localparam int CW    = $clog2(CLR_N);

    logic [DATA_W-1:0] mem [MAX_POSITIONS];

    logic [STEP_W-1:0] upc_reg, upc_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SIZE_W-1:0] size_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [DATA_W-1:0] rdata_reg;

    ctrl_word_t        cw;
    logic [SIZE_W-1:0] eff_size;
    logic [POS_W-1:0]  low_bit;
    logic [XW-1:0]     pos_x;
    logic              accept;
    logic              out_free;
    logic              out_range;
    logic              cnt_last;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [STEP_W-1:0] dispatch_step;

    assign cw = rom_word(upc_reg);

    assign eff_size = (32'(size_reg) > 32'(MAX_POSITIONS)) ? SIZE_W'(MAX_POSITIONS) : size_reg;
    assign low_bit  = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_x    = XW'(pos_reg) - XW'(1);
    assign cnt_last = (cnt_reg == CW'(CLR_N - 1));

    assign items.ready    = (cw.act == A_FETCH);
    assign accept         = items.valid && items.ready;
    assign out_free       = !out_valid_reg || results.ready;
    assign results.valid      = out_valid_reg;
    assign results.prefix_sum = out_data_reg;
    assign size_cfg.ready = 1'b1;

    always_comb
    begin
        case (items.command)
            CMD_ADD:   dispatch_step = STEP_ADD_CHK;
            CMD_QUERY: dispatch_step = STEP_QRY_CLMP;
            CMD_CLEAR: dispatch_step = STEP_CLR;
            default:   dispatch_step = STEP_FIN;
        endcase
    end

    // datapath driven by the current control word
    always_comb
    begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        delta_next     = delta_reg;
        cnt_next       = cnt_reg;
        out_valid_next = (out_valid_reg && !results.ready);
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_addr       = pos_x[AW-1:0];
        mem_wdata      = rdata_reg + delta_reg;
        case (cw.act)
            A_FETCH:
            begin
                if (accept)
                begin
                    pos_next   = {1'b0, items.index};
                    delta_next = items.delta;
                    acc_next   = '0;
                end
            end
            A_WRITE:
            begin
                mem_we   = 1'b1;
                pos_next = pos_reg + low_bit;
            end
            A_CLAMP:
            begin
                if (pos_reg > {1'b0, eff_size})
                begin
                    pos_next = {1'b0, eff_size};
                end
            end
            A_ACC:
            begin
                acc_next = acc_reg + rdata_reg;
                pos_next = pos_reg - low_bit;
            end
            A_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = AW'(cnt_reg);
                mem_wdata = '0;
                cnt_next  = cnt_last ? '0 : cnt_reg + CW'(1);
            end
            A_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_range = (pos_next == '0) || (pos_next > {1'b0, eff_size});

    // step counter
    always_comb
    begin
        case (cw.cond)
            C_SEQ:      upc_next = upc_reg + STEP_W'(1);
            C_GO:       upc_next = cw.target;
            C_DISPATCH: upc_next = accept ? dispatch_step : upc_reg;
            C_OUT:      upc_next = out_range ? cw.target : upc_reg + STEP_W'(1);
            C_IN:       upc_next = out_range ? upc_reg + STEP_W'(1) : cw.target;
            C_SWEEP:    upc_next = cnt_last ? upc_reg + STEP_W'(1) : cw.target;
            C_WAIT_OUT: upc_next = out_free ? cw.target : upc_reg;
            default:    upc_next = STEP_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= STEP_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            size_reg      <= SIZE_RESET;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (size_cfg.valid && size_cfg.ready)
            begin
                size_reg <= size_cfg.active_size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        delta_reg    <= delta_next;
        out_data_reg <= out_data_next;
    end

    // partial-sum store, position p at address p-1
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

endmodule
